[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Each macro clocks on the given clock and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[rtl/core/stcd_pkg.sv]
// Shared types, constants and helper functions of the scale template detector.
// Used by every RTL module of the block; depends on nothing else.
package stcd_pkg;

  localparam int unsigned NUM_PC        = 12;
  localparam int unsigned MAX_TEMPLATES = 8;
  localparam int unsigned SLOTS_PER_BANK = 4;
  localparam int unsigned BANK_W        = NUM_PC * SLOTS_PER_BANK;
  localparam int unsigned TCOUNT_W      = 4;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned SCALE_W       = $clog2(MAX_TEMPLATES);
  localparam int unsigned ROOT_W        = 4;
  localparam int unsigned POP_W         = 4;
  localparam int unsigned NOTE_W        = 7;
  localparam int unsigned SCORE_W       = 11;
  localparam int unsigned FIT_W         = 10;
  localparam int unsigned BONUS_W       = 7;
  localparam int unsigned RECIP_SHIFT   = 18;
  localparam int unsigned RECIP_W       = 28;
  localparam int unsigned PROD_W        = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [NUM_PC-1:0] pc_set_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BANK_A = 2'd0,
    CFG_BANK_B = 2'd1,
    CFG_COUNT  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note_number;
    logic              follows_chord;
    logic              last_note;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [ROOT_W-1:0]  root_pc;
    logic [SCALE_W-1:0] tmpl_idx;
    logic [SCORE_W-1:0] match_score;
  } out_word_t;

  typedef struct packed {
    logic [BANK_W-1:0]   bank_a;
    logic [BANK_W-1:0]   bank_b;
    logic [TCOUNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic    push;
    pc_set_t set;
  } q_push_t;

  typedef struct packed {
    logic    valid;
    pc_set_t set;
  } q_head_t;

  // The quotient note/12 is taken as (note*43)>>9, exact for all 7-bit notes.
  function automatic logic [ROOT_W-1:0] note_to_pc(input logic [NOTE_W-1:0] note);
    logic [12:0]       prod;
    logic [3:0]        quo;
    logic [NOTE_W-1:0] rem;
    prod = 13'(note) * 13'd43;
    quo  = prod[12:9];
    rem  = note - 7'(quo) * 7'd12;
    return rem[ROOT_W-1:0];
  endfunction

  function automatic logic [POP_W-1:0] popcount12(input pc_set_t v);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < NUM_PC; i++) begin
      c = c + POP_W'(v[i]);
    end
    return c;
  endfunction

  function automatic pc_set_t rot12(input pc_set_t m, input logic [ROOT_W-1:0] r);
    logic [2*NUM_PC-1:0] d;
    d = {m, m} >> (ROOT_W'(NUM_PC) - r);
    return d[NUM_PC-1:0];
  endfunction

  // 1000 * ceil(2^18 / total); a product with the hit count shifted right by 18
  // gives hits*1000/total exactly for every total from 1 to 12.
  function automatic logic [RECIP_W-1:0] recip_1000(input logic [POP_W-1:0] total);
    logic [RECIP_W-1:0] w;
    case (total)
      4'd1:    w = 28'd262144000;
      4'd2:    w = 28'd131072000;
      4'd3:    w = 28'd87382000;
      4'd4:    w = 28'd65536000;
      4'd5:    w = 28'd52429000;
      4'd6:    w = 28'd43691000;
      4'd7:    w = 28'd37450000;
      4'd8:    w = 28'd32768000;
      4'd9:    w = 28'd29128000;
      4'd10:   w = 28'd26215000;
      4'd11:   w = 28'd23832000;
      4'd12:   w = 28'd21846000;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [BONUS_W-1:0] template_bonus(input logic [POP_W-1:0] size);
    logic [BONUS_W-1:0] b;
    case (size)
      4'd1:    b = 7'd100;
      4'd2:    b = 7'd50;
      4'd3:    b = 7'd33;
      4'd4:    b = 7'd25;
      4'd5:    b = 7'd20;
      4'd6:    b = 7'd16;
      4'd7:    b = 7'd14;
      4'd8:    b = 7'd12;
      4'd9:    b = 7'd11;
      4'd10:   b = 7'd10;
      4'd11:   b = 7'd9;
      4'd12:   b = 7'd8;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/stcd_queue.sv]
// Short queue of finished pitch sets between the front and the back part.
// Depends on stcd_pkg.
module stcd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  stcd_pkg::q_push_t push_in,
  input  logic              pop,
  output stcd_pkg::q_head_t head,
  output logic              full
);

  stcd_pkg::pc_set_t                mem_r [stcd_pkg::QUEUE_DEPTH];
  logic [stcd_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [stcd_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [stcd_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             do_push, do_pop;

  assign full    = (count_r == stcd_pkg::QCNT_W'(stcd_pkg::QUEUE_DEPTH));
  assign do_push = push_in.push && !full;
  assign do_pop  = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.set   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == stcd_pkg::QPTR_W'(stcd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == stcd_pkg::QPTR_W'(stcd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      if (do_push) begin
        mem_r[wr_ptr_r] <= push_in.set;
      end
    end
  end

endmodule

[rtl/core/stcd_front.sv]
// Front part: accepts note words and gathers their pitch classes into a set.
// Depends on stcd_pkg; hands each finished set to stcd_queue.
module stcd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  stcd_pkg::in_word_t in_word,
  output logic               in_stall,
  input  logic               q_full,
  output stcd_pkg::q_push_t  push_out
);

  stcd_pkg::pc_set_t pitch_set_r, pitch_set_nxt;
  stcd_pkg::pc_set_t note_bit;
  stcd_pkg::pc_set_t merged;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    note_bit = '0;
    if (in_word.follows_chord && (in_word.note_number != '0)) begin
      note_bit = stcd_pkg::pc_set_t'(1) << stcd_pkg::note_to_pc(in_word.note_number);
    end
    merged        = pitch_set_r | note_bit;
    pitch_set_nxt = pitch_set_r;
    if (accept) begin
      pitch_set_nxt = in_word.last_note ? '0 : merged;
    end
  end

  assign push_out.push = accept && in_word.last_note;
  assign push_out.set  = merged;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_set_r <= '0;
    end else begin
      pitch_set_r <= pitch_set_nxt;
    end
  end

endmodule

[rtl/core/stcd_back.sv]
// Back part: sweeps every root and template for one pitch set and keeps the best.
// Depends on stcd_pkg; takes sets from stcd_queue and drives the result register.
module stcd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  stcd_pkg::cfg_t      cfg,
  input  stcd_pkg::q_head_t   head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output stcd_pkg::out_word_t out_word
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t                               state_r;
  stcd_pkg::pc_set_t                    set_r;
  logic [stcd_pkg::RECIP_W-1:0]         recip_r;
  logic [stcd_pkg::ROOT_W-1:0]          root_r;
  logic [stcd_pkg::SCALE_W-1:0]         k_r;
  logic [stcd_pkg::SCALE_W-1:0]         cnt_m1_r;
  logic                                 s1_vld_r;
  logic [stcd_pkg::ROOT_W-1:0]          s1_root_r;
  logic [stcd_pkg::SCALE_W-1:0]         s1_k_r;
  logic [stcd_pkg::POP_W-1:0]           s1_ins_r;
  logic [stcd_pkg::BONUS_W-1:0]         s1_bonus_r;
  logic                                 s1_empty_r;
  logic                                 lead_vld_r;
  logic [stcd_pkg::SCORE_W-1:0]         lead_score_r;
  logic [stcd_pkg::ROOT_W-1:0]          lead_root_r;
  logic [stcd_pkg::SCALE_W-1:0]         lead_k_r;
  stcd_pkg::out_word_t                  out_word_r;

  logic [stcd_pkg::BANK_W-1:0]          bank;
  stcd_pkg::pc_set_t                    tmpl;
  logic [stcd_pkg::POP_W-1:0]           tmpl_size;
  logic [stcd_pkg::POP_W-1:0]           hit_count;
  logic [stcd_pkg::SCALE_W-1:0]         cnt_m1;
  logic [stcd_pkg::PROD_W-1:0]          prod;
  logic [stcd_pkg::FIT_W-1:0]           fit;
  logic [stcd_pkg::SCORE_W-1:0]         score;
  logic                                 take;
  logic [stcd_pkg::SCORE_W-1:0]         new_score;
  logic [stcd_pkg::ROOT_W-1:0]          new_root;
  logic [stcd_pkg::SCALE_W-1:0]         new_k;

  always_comb begin
    bank = k_r[stcd_pkg::SCALE_W-1] ? cfg.bank_b : cfg.bank_a;
    case (k_r[1:0])
      2'd0:    tmpl = bank[0*stcd_pkg::NUM_PC +: stcd_pkg::NUM_PC];
      2'd1:    tmpl = bank[1*stcd_pkg::NUM_PC +: stcd_pkg::NUM_PC];
      2'd2:    tmpl = bank[2*stcd_pkg::NUM_PC +: stcd_pkg::NUM_PC];
      default: tmpl = bank[3*stcd_pkg::NUM_PC +: stcd_pkg::NUM_PC];
    endcase
    tmpl_size = stcd_pkg::popcount12(tmpl);
    hit_count = stcd_pkg::popcount12(set_r & stcd_pkg::rot12(tmpl, root_r));
  end

  always_comb begin
    if (cfg.count == '0) begin
      cnt_m1 = '0;
    end else if (cfg.count > stcd_pkg::TCOUNT_W'(stcd_pkg::MAX_TEMPLATES)) begin
      cnt_m1 = stcd_pkg::SCALE_W'(stcd_pkg::MAX_TEMPLATES - 1);
    end else begin
      cnt_m1 = stcd_pkg::SCALE_W'(cfg.count - 1'b1);
    end
  end

  always_comb begin
    prod  = stcd_pkg::PROD_W'(s1_ins_r) * stcd_pkg::PROD_W'(recip_r);
    fit   = prod[stcd_pkg::RECIP_SHIFT +: stcd_pkg::FIT_W];
    score = s1_empty_r ? '0 :
            stcd_pkg::SCORE_W'(fit) + stcd_pkg::SCORE_W'(s1_bonus_r);
    take  = !lead_vld_r || (score > lead_score_r);
    new_score = take ? score     : lead_score_r;
    new_root  = take ? s1_root_r : lead_root_r;
    new_k     = take ? s1_k_r    : lead_k_r;
  end

  assign pop       = (state_r == ST_IDLE) && head.valid;
  assign out_valid = (state_r == ST_OUT);
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_vld_r   <= 1'b0;
      lead_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= (state_r == ST_SWEEP);
      if (s1_vld_r) begin
        lead_vld_r   <= 1'b1;
        lead_score_r <= new_score;
        lead_root_r  <= new_root;
        lead_k_r     <= new_k;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (head.valid) begin
            set_r      <= head.set;
            recip_r    <= stcd_pkg::recip_1000(stcd_pkg::popcount12(head.set));
            cnt_m1_r   <= cnt_m1;
            root_r     <= '0;
            k_r        <= '0;
            lead_vld_r <= 1'b0;
            if (head.set == '0) begin
              out_word_r <= '0;
              state_r    <= ST_OUT;
            end else begin
              state_r <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          s1_root_r  <= root_r;
          s1_k_r     <= k_r;
          s1_ins_r   <= hit_count;
          s1_bonus_r <= stcd_pkg::template_bonus(tmpl_size);
          s1_empty_r <= (tmpl_size == '0);
          if (k_r == cnt_m1_r) begin
            k_r <= '0;
            if (root_r == stcd_pkg::ROOT_W'(stcd_pkg::NUM_PC - 1)) begin
              state_r <= ST_FLUSH;
            end else begin
              root_r <= root_r + 1'b1;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_FLUSH: begin
          out_word_r.found       <= 1'b1;
          out_word_r.root_pc     <= new_root;
          out_word_r.tmpl_idx    <= new_k;
          out_word_r.match_score <= new_score;
          state_r                <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/scale_template_detector.sv]
// Top level of the scale template detector: configuration registers and the
// front, queue and back parts. Depends on stcd_pkg and the stcd_* modules.
// Notes are taken one per cycle while the two-entry set queue has room.
// A set is queued when its last_note word is accepted; the idle back part takes it,
// sweeps it (skipped for an empty set), then registers and offers the result. It
// scores one root/template pair per cycle and takes a new set only once idle again.
// Reset is synchronous: pitch set, queue and sweep clear, templates clear, count is one.
module scale_template_detector (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  stcd_pkg::in_word_t                    in_word,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output stcd_pkg::out_word_t                   out_word,
  input  logic                                  cfg_we,
  input  logic [stcd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [stcd_pkg::BANK_W-1:0]           cfg_wdata
);

  stcd_pkg::cfg_t    cfg_r;
  stcd_pkg::q_push_t q_push;
  stcd_pkg::q_head_t q_head;
  logic              q_full;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bank_a <= '0;
      cfg_r.bank_b <= '0;
      cfg_r.count  <= stcd_pkg::TCOUNT_W'(1);
    end else if (cfg_we) begin
      unique case (stcd_pkg::cfg_idx_t'(cfg_index))
        stcd_pkg::CFG_BANK_A: cfg_r.bank_a <= cfg_wdata;
        stcd_pkg::CFG_BANK_B: cfg_r.bank_b <= cfg_wdata;
        stcd_pkg::CFG_COUNT:  cfg_r.count  <= cfg_wdata[stcd_pkg::TCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  stcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push_out (q_push)
  );

  stcd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_in (q_push),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full)
  );

  stcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[rtl/core/stcd_checker.sv]
// Port-level checks on the result channel of the scale template detector.
// Depends on stcd_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module stcd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input stcd_pkg::out_word_t out_word
);

  logic empty_clear;
  logic found_legal;

  assign empty_clear = (out_word.root_pc == '0) && (out_word.tmpl_idx == '0) &&
                       (out_word.match_score == '0);
  assign found_legal = (out_word.root_pc <= 4'd11) && (out_word.match_score <= 11'd1100);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_word))
  `ASSERT_IMPL(a_empty_zero, clk, rst_n, out_valid && !out_word.found, empty_clear)
  `ASSERT_IMPL(a_found_range, clk, rst_n, out_valid && out_word.found, found_legal)

endmodule

bind scale_template_detector stcd_checker u_stcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

[dv/scale_template_detector_test.sv]
// Self-checking testbench for scale_template_detector: random and directed note words,
// template and count settings, and a scoreboard that predicts each detection.
// Depends on stcd_pkg and the RTL of the block only.
import stcd_pkg::*;

class scale_scoreboard;
  logic [BANK_W-1:0]   bank_a;
  logic [BANK_W-1:0]   bank_b;
  logic [TCOUNT_W-1:0] tcount;
  pc_set_t             pitch_set;
  out_word_t           pending_matches[$];
  int                  errors;

  function new();
    bank_a    = '0;
    bank_b    = '0;
    tcount    = TCOUNT_W'(1);
    pitch_set = '0;
    errors    = 0;
  endfunction

  function void set_reg(cfg_idx_t idx, logic [BANK_W-1:0] value);
    case (idx)
      CFG_BANK_A: bank_a = value;
      CFG_BANK_B: bank_b = value;
      CFG_COUNT: tcount = value[TCOUNT_W-1:0];
      default: ;
    endcase
  endfunction

  function out_word_t best_match();
    out_word_t          m;
    int unsigned        n;
    int unsigned        total;
    int unsigned        size;
    int unsigned        hits;
    int unsigned        score;
    int                 best;
    logic [NUM_PC-1:0]  tmpl;
    logic [2*NUM_PC-1:0] wide;
    m = '0;
    if (pitch_set == '0) return m;
    n = (tcount == 0) ? 1 : ((tcount > MAX_TEMPLATES) ? MAX_TEMPLATES : tcount);
    total = $countones(pitch_set);
    best = -1;
    m.found = 1'b1;
    for (int r = 0; r < NUM_PC; r++) begin
      for (int k = 0; k < int'(n); k++) begin
        if (k < SLOTS_PER_BANK) tmpl = bank_a[NUM_PC*k +: NUM_PC];
        else tmpl = bank_b[NUM_PC*(k-SLOTS_PER_BANK) +: NUM_PC];
        wide = {{NUM_PC{1'b0}}, tmpl} << r;
        size = $countones(tmpl);
        score = 0;
        if (size != 0) begin
          hits = $countones(pitch_set & (wide[NUM_PC-1:0] | wide[2*NUM_PC-1:NUM_PC]));
          score = hits * 1000 / total + 100 / size;
        end
        if (int'(score) > best) begin
          best = score;
          m.root_pc = ROOT_W'(r);
          m.tmpl_idx = SCALE_W'(k);
          m.match_score = SCORE_W'(score);
        end
      end
    end
    return m;
  endfunction

  function void note_accepted(in_word_t w);
    if (w.follows_chord && w.note_number != 0) pitch_set[w.note_number % NUM_PC] = 1'b1;
    if (w.last_note) begin
      pending_matches.push_back(best_match());
      pitch_set = '0;
    end
  endfunction

  function void check_match(out_word_t got);
    out_word_t want;
    if (pending_matches.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word found=%0d root=%0d scale=%0d score=%0d",
               $time, got.found, got.root_pc, got.tmpl_idx, got.match_score);
      return;
    end
    want = pending_matches.pop_front();
    if (got.found !== want.found || got.root_pc !== want.root_pc ||
        got.tmpl_idx !== want.tmpl_idx || got.match_score !== want.match_score) begin
      errors++;
      $display("%0t: expected found=%0d root=%0d scale=%0d score=%0d,",
               $time, want.found, want.root_pc, want.tmpl_idx, want.match_score,
               " got found=%0d root=%0d scale=%0d score=%0d",
               got.found, got.root_pc, got.tmpl_idx, got.match_score);
    end
  endfunction
endclass

module scale_template_detector_test;
  localparam int SETTLE_CYCLES = 12 * MAX_TEMPLATES + 24;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int PHASES        = 8;
  localparam int PHASE_NOTES   = 225;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [BANK_W-1:0]     cfg_wdata;

  scale_scoreboard board = new();
  int cycles = 0;
  int notes_sent = 0;
  bit burst = 1'b0;

  scale_template_detector dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("scale_template_detector verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_match(out_word);
  end

  initial begin
    int run;
    out_stall = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (run) begin
        @(negedge clk) out_stall <= 1'b0;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 3);
      repeat (run) begin
        @(negedge clk) out_stall <= 1'b1;
      end
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [NOTE_W-1:0] random_note();
    if ($urandom_range(0, 15) == 0) return '0;
    return NOTE_W'($urandom_range(1, 127));
  endfunction

  function automatic logic [BANK_W-1:0] random_bank();
    logic [BANK_W-1:0] b;
    int pick;
    for (int k = 0; k < SLOTS_PER_BANK; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) b[NUM_PC*k +: NUM_PC] = 12'h000;
      else if (pick == 2) b[NUM_PC*k +: NUM_PC] = 12'hFFF;
      else b[NUM_PC*k +: NUM_PC] = NUM_PC'($urandom);
    end
    return b;
  endfunction

  task automatic send_note(logic [NOTE_W-1:0] note, logic follows, logic last);
    in_word_t w;
    int gap;
    w.note_number = note;
    w.follows_chord = follows;
    w.last_note = last;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    board.note_accepted(w);
    notes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (board.pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [BANK_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    board.set_reg(idx, value);
  endtask

  task automatic configure(int phase);
    logic [BANK_W-1:0] a;
    logic [BANK_W-1:0] b;
    logic [BANK_W-1:0] c;
    a = random_bank();
    b = random_bank();
    c = BANK_W'({$urandom, $urandom});
    case (phase % 6)
      0: c[TCOUNT_W-1:0] = TCOUNT_W'(8);
      1: c[TCOUNT_W-1:0] = '0;
      2: begin
        a = '1;
        b = '1;
        c[TCOUNT_W-1:0] = '1;
      end
      3: begin
        a = '0;
        b = '0;
        c[TCOUNT_W-1:0] = TCOUNT_W'(1);
      end
      4: c[TCOUNT_W-1:0] = TCOUNT_W'($urandom_range(1, 7));
      default: c[TCOUNT_W-1:0] = TCOUNT_W'($urandom);
    endcase
    write_reg(CFG_BANK_A, a);
    write_reg(CFG_BANK_B, b);
    write_reg(CFG_COUNT, c);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic random_set();
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    len = $urandom_range(1, 10);
    burst = ($urandom_range(0, 6) == 0);
    for (int i = 0; i < len; i++) begin
      if (kind < 80) send_note(random_note(), $urandom_range(0, 15) != 0, i == len - 1);
      else if (kind < 90) begin
        if ($urandom_range(0, 1) == 0) send_note(random_note(), 1'b0, i == len - 1);
        else send_note('0, 1'b1, i == len - 1);
      end else send_note(NOTE_W'($urandom), 1'($urandom), 1'($urandom));
    end
    burst = 1'b0;
  endtask

  initial begin
    int start;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_BANK_A;
    cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // With the reset templates all empty, any non-empty set scores zero at root zero.
    send_note('0, 1'b1, 1'b1);
    send_note(NOTE_W'(60), 1'b1, 1'b0);
    send_note(NOTE_W'(127), 1'b0, 1'b1);
    wait_idle();

    write_reg(CFG_BANK_A, {12'h000, 12'h001, 12'h5AD, 12'hAB5});
    write_reg(CFG_BANK_B, {12'hFFF, 12'h091, 12'h249, 12'h000});
    write_reg(CFG_COUNT, BANK_W'(8));
    @(negedge clk) cfg_we <= 1'b0;

    send_note(NOTE_W'(60), 1'b1, 1'b0);
    send_note(NOTE_W'(64), 1'b1, 1'b0);
    send_note(NOTE_W'(67), 1'b1, 1'b1);
    send_note(NOTE_W'(57), 1'b1, 1'b0);
    send_note(NOTE_W'(60), 1'b1, 1'b0);
    send_note(NOTE_W'(64), 1'b1, 1'b1);
    send_note(NOTE_W'(127), 1'b1, 1'b1);
    for (int i = 1; i <= NUM_PC; i++) send_note(NOTE_W'(i), 1'b1, i == NUM_PC);
    send_note(NOTE_W'(127), 1'b0, 1'b0);
    send_note('0, 1'b1, 1'b1);
    wait_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      configure(phase);
      start = notes_sent;
      while (notes_sent - start < PHASE_NOTES) random_set();
      send_note(random_note(), 1'b1, 1'b1);
      wait_idle();
    end

    if (board.errors == 0 && board.pending_matches.size() == 0)
      $display("scale_template_detector verification clean");
    else
      $display("scale_template_detector verification failed");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/stcd_pkg.sv
rtl/core/stcd_queue.sv
rtl/core/stcd_front.sv
rtl/core/stcd_back.sv
rtl/core/scale_template_detector.sv
rtl/core/stcd_checker.sv
dv/scale_template_detector_test.sv
